>>> rtl/dfr_pkg.sv
// dfr_pkg: shared types and constants of the delimited frame receiver
// no dependencies; imported by every module of the block but dfr_ram
`timescale 1ns / 1ps
`default_nettype none

package dfr_pkg;

  localparam int unsigned PAYLOAD_DEPTH_DEF = 16;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 16;
  localparam int unsigned BYTE_IDX_W  = 4;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [BYTE_W-1:0] START_MARK    = 8'h7E;
  localparam logic [BYTE_W-1:0] CSUM_BASE     = 8'hFF;
  localparam logic [LEN_W-1:0]  TIMEOUT_RESET = 16'd200;

  typedef enum logic [STATUS_W-1:0] {
    ST_GOOD    = 2'd0,
    ST_CSUM    = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_OVER    = 2'd3
  } status_e;

  // one finished frame handed from the parser to the result side
  typedef struct packed {
    status_e           status;
    logic [LEN_W-1:0]  len;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/delimited_frame_receiver_top.sv
// delimited frame receiver: an input transaction is taken whenever full is low; in
// the body phase a transaction waits while a finished frame is queued or is still
// read out of the payload store, and any transaction waits while the job queue
// holds two finished frames. a finished frame passes through the job queue and the
// output register to the result ports; a good payload is read out byte by byte, each
// byte through the store's registered read. reset clears all control state and sets
// timeout_ticks to 200; the payload store is not cleared. depends on dfr_pkg and the dfr_* modules
`timescale 1ns / 1ps
`default_nettype none

module delimited_frame_receiver_top
  import dfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [LEN_W-1:0]      cfg_data_i,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  command_i,
  input  wire logic [BYTE_W-1:0]     rx_byte_i,
  input  wire logic                  pop,
  output logic                       empty,
  output logic [STATUS_W-1:0]        status_o,
  output logic [BYTE_W-1:0]          data_byte_o,
  output logic [BYTE_IDX_W-1:0]      byte_index_o,
  output logic [LEN_W-1:0]           frame_length_o,
  output logic                       has_data_o,
  output logic                       last_o
);

  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  logic [LEN_W-1:0]  timeout_q;
  logic              job_push, job_pop, job_full, job_valid;
  job_t              job_in, job_out;
  logic              back_busy;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data, rd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  dfr_front #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .command_i       (command_i),
    .rx_byte_i       (rx_byte_i),
    .timeout_ticks_i (timeout_q),
    .drain_busy_i    (job_valid | back_busy),
    .job_full_i      (job_full),
    .full_o          (full),
    .job_push_o      (job_push),
    .job_o           (job_in),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data)
  );

  dfr_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .pop_i   (job_pop),
    .full_o  (job_full),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  dfr_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(PAYLOAD_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dfr_back #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job_out),
    .job_pop_o      (job_pop),
    .busy_o         (back_busy),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .pop_i          (pop),
    .empty_o        (empty),
    .status_o       (status_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .has_data_o     (has_data_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

>>> rtl/dfr_ram.sv
// dfr_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module dfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/dfr_front.sv
// dfr_front: accepts bytes and ticks, parses frames, runs the idle timer,
// writes the payload store and posts one job per finished frame; uses dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfr_front
  import dfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic              command_i,
  input  wire logic [BYTE_W-1:0] rx_byte_i,
  input  wire logic [LEN_W-1:0]  timeout_ticks_i,
  input  wire logic              drain_busy_i,
  input  wire logic              job_full_i,
  output logic                   full_o,
  output logic                   job_push_o,
  output job_t                   job_o,
  output logic                   wr_en_o,
  output logic [AW-1:0]          wr_addr_o,
  output logic [BYTE_W-1:0]      wr_data_o
);

  typedef enum logic [3:0] {
    P_START  = 4'b0001,
    P_LEN_HI = 4'b0010,
    P_LEN_LO = 4'b0100,
    P_BODY   = 4'b1000
  } phase_e;

  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(PAYLOAD_DEPTH);

  phase_e            phase_q, phase_d;
  logic [LEN_W-1:0]  decl_len_q, decl_len_d;
  logic [LEN_W-1:0]  taken_q, taken_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [LEN_W-1:0]  timer_q, timer_d;
  logic [LEN_W-1:0]  timer_load;
  logic [BYTE_W-1:0] csum_expect;
  logic              accept;

  // body-phase items wait while a frame is queued or still read from the store
  assign full_o      = job_full_i | ((phase_q == P_BODY) & drain_busy_i);
  assign accept      = push_i & ~full_o;
  assign timer_load  = (timeout_ticks_i == '0) ? LEN_W'(1) : timeout_ticks_i;
  assign csum_expect = CSUM_BASE - sum_q;

  assign wr_addr_o = taken_q[AW-1:0];
  assign wr_data_o = rx_byte_i;

  always_comb begin
    phase_d    = phase_q;
    decl_len_d = decl_len_q;
    taken_d    = taken_q;
    sum_d      = sum_q;
    timer_d    = timer_q;
    job_push_o = 1'b0;
    job_o      = '{status: ST_GOOD, len: decl_len_q};
    wr_en_o    = 1'b0;

    if (accept) begin
      if (command_i) begin
        if ((phase_q != P_START) && (timer_q != '0)) begin
          timer_d = timer_q - LEN_W'(1);
          if (timer_q == LEN_W'(1)) begin
            phase_d    = P_START;
            taken_d    = '0;
            sum_d      = '0;
            job_push_o = 1'b1;
            job_o      = '{status: ST_TIMEOUT, len: '0};
          end
        end
      end else begin
        case (phase_q)
          P_START: begin
            if (rx_byte_i == START_MARK) begin
              phase_d = P_LEN_HI;
              taken_d = '0;
              sum_d   = '0;
              timer_d = timer_load;
            end
          end
          P_LEN_HI: begin
            decl_len_d = {rx_byte_i, 8'h00};
            phase_d    = P_LEN_LO;
            timer_d    = timer_load;
          end
          P_LEN_LO: begin
            decl_len_d = {decl_len_q[15:8], rx_byte_i};
            phase_d    = P_BODY;
            timer_d    = timer_load;
          end
          P_BODY: begin
            if (taken_q < decl_len_q) begin
              wr_en_o = (taken_q < DEPTH_LEN);
              taken_d = taken_q + LEN_W'(1);
              sum_d   = sum_q + rx_byte_i;
              timer_d = timer_load;
            end else begin
              // checksum byte closes the frame
              job_push_o = 1'b1;
              if (decl_len_q > DEPTH_LEN) begin
                job_o.status = ST_OVER;
              end else if (csum_expect != rx_byte_i) begin
                job_o.status = ST_CSUM;
              end else begin
                job_o.status = ST_GOOD;
              end
              phase_d = P_START;
              taken_d = '0;
              sum_d   = '0;
              timer_d = '0;
            end
          end
          default: begin
            phase_d = P_START;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= P_START;
      decl_len_q <= '0;
      taken_q    <= '0;
      sum_q      <= '0;
      timer_q    <= '0;
    end else begin
      phase_q    <= phase_d;
      decl_len_q <= decl_len_d;
      taken_q    <= taken_d;
      sum_q      <= sum_d;
      timer_q    <= timer_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dfr_job_fifo.sv
// dfr_job_fifo: two-entry queue of finished frame jobs between parser and
// result side; uses dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfr_job_fifo
  import dfr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t data_i,
  input  wire logic pop_i,
  output logic      full_o,
  output logic      valid_o,
  output job_t      data_o
);

  job_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/dfr_back.sv
// dfr_back: takes jobs, reads good payloads out of the store and presents
// results in an output register; uses dfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dfr_back
  import dfr_pkg::*;
#(
  parameter int unsigned PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF,
  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  job_valid_i,
  input  wire job_t                  job_i,
  output logic                       job_pop_o,
  output logic                       busy_o,
  output logic                       rd_en_o,
  output logic [AW-1:0]              rd_addr_o,
  input  wire logic [BYTE_W-1:0]     rd_data_i,
  input  wire logic                  pop_i,
  output logic                       empty_o,
  output logic [STATUS_W-1:0]        status_o,
  output logic [BYTE_W-1:0]          data_byte_o,
  output logic [BYTE_IDX_W-1:0]      byte_index_o,
  output logic [LEN_W-1:0]           frame_length_o,
  output logic                       has_data_o,
  output logic                       last_o
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_RD   = 3'b010,
    B_WR   = 3'b100
  } bstate_e;

  bstate_e           state_q, state_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              load;
  logic              drain_last;

  status_e               o_status_q, o_status_d;
  logic [BYTE_W-1:0]     o_data_q, o_data_d;
  logic [BYTE_IDX_W-1:0] o_idx_q, o_idx_d;
  logic [LEN_W-1:0]      o_len_q, o_len_d;
  logic                  o_has_q, o_has_d;
  logic                  o_last_q, o_last_d;

  assign out_free   = ~out_valid_q | pop_i;
  assign busy_o     = (state_q != B_IDLE);
  assign rd_addr_o  = cnt_q;
  assign drain_last = ((LEN_W'(cnt_q) + LEN_W'(1)) == len_q);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    job_pop_o  = 1'b0;
    rd_en_o    = 1'b0;
    load       = 1'b0;
    o_status_d = o_status_q;
    o_data_d   = o_data_q;
    o_idx_d    = o_idx_q;
    o_len_d    = o_len_q;
    o_has_d    = o_has_q;
    o_last_d   = o_last_q;

    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          if ((job_i.status == ST_GOOD) && (job_i.len != '0)) begin
            job_pop_o = 1'b1;
            cnt_d     = '0;
            len_d     = job_i.len;
            state_d   = B_RD;
          end else if (out_free) begin
            // errors and empty frames give one result on their own
            job_pop_o  = 1'b1;
            load       = 1'b1;
            o_status_d = job_i.status;
            o_data_d   = '0;
            o_idx_d    = '0;
            o_len_d    = job_i.len;
            o_has_d    = 1'b0;
            o_last_d   = 1'b1;
          end
        end
      end
      B_RD: begin
        rd_en_o = 1'b1;
        state_d = B_WR;
      end
      B_WR: begin
        if (out_free) begin
          load       = 1'b1;
          o_status_d = ST_GOOD;
          o_data_d   = rd_data_i;
          o_idx_d    = BYTE_IDX_W'(cnt_q);
          o_len_d    = len_q;
          o_has_d    = 1'b1;
          o_last_d   = drain_last;
          if (drain_last) begin
            state_d = B_IDLE;
          end else begin
            cnt_d   = cnt_q + AW'(1);
            state_d = B_RD;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    out_valid_d = load | (out_valid_q & ~pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_status_q <= o_status_d;
    o_data_q   <= o_data_d;
    o_idx_q    <= o_idx_d;
    o_len_q    <= o_len_d;
    o_has_q    <= o_has_d;
    o_last_q   <= o_last_d;
  end

  assign empty_o        = ~out_valid_q;
  assign status_o       = o_status_q;
  assign data_byte_o    = o_data_q;
  assign byte_index_o   = o_idx_q;
  assign frame_length_o = o_len_q;
  assign has_data_o     = o_has_q;
  assign last_o         = o_last_q;

endmodule

`default_nettype wire

>>> test/tb_delimited_frame_receiver_top.sv
// tb_delimited_frame_receiver_top: self-checking testbench of the delimited frame receiver
// drives byte and tick transactions, predicts every result and checks it at the outputs
// depends on dfr_pkg and delimited_frame_receiver_top
`timescale 1ns / 1ps

module tb_delimited_frame_receiver_top;
  import dfr_pkg::*;

  localparam int unsigned DEPTH         = PAYLOAD_DEPTH_DEF;
  localparam logic        CMD_BYTE      = 1'b0;
  localparam logic        CMD_TICK      = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_ITEMS  = 260;

  typedef enum logic [1:0] {PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_BODY} rx_phase_e;

  typedef struct {
    status_e                 status;
    logic [BYTE_W-1:0]       data;
    logic [BYTE_IDX_W-1:0]   idx;
    logic [LEN_W-1:0]        len;
    logic                    has_data;
    logic                    last;
  } frame_result_t;

  typedef logic [BYTE_W-1:0] byte_q_t[$];

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic [LEN_W-1:0]      cfg_data_i  = '0;
  logic                  push        = 1'b0;
  logic                  command_i   = CMD_BYTE;
  logic [BYTE_W-1:0]     rx_byte_i   = '0;
  logic                  pop         = 1'b0;
  logic                  cfg_ready_o;
  logic                  full;
  logic                  empty;
  logic [STATUS_W-1:0]   status_o;
  logic [BYTE_W-1:0]     data_byte_o;
  logic [BYTE_IDX_W-1:0] byte_index_o;
  logic [LEN_W-1:0]      frame_length_o;
  logic                  has_data_o;
  logic                  last_o;

  // receiver model state
  logic [LEN_W-1:0]  timeout_setting = TIMEOUT_RESET;
  rx_phase_e         rx_phase        = PH_HUNT;
  logic [LEN_W-1:0]  declared_len    = '0;
  logic [LEN_W-1:0]  bytes_seen      = '0;
  logic [LEN_W-1:0]  idle_count      = '0;
  logic [BYTE_W-1:0] body_sum        = '0;
  logic [BYTE_W-1:0] body_store [DEPTH];
  frame_result_t     expected_results[$];

  int unsigned live_items    = 0;
  int unsigned error_count   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned pop_stall_pct = 0;
  int unsigned quiet_cycles  = 0;
  logic        holding       = 1'b0;
  event        hold_go;

  delimited_frame_receiver_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .rx_byte_i      (rx_byte_i),
    .pop            (pop),
    .empty          (empty),
    .status_o       (status_o),
    .data_byte_o    (data_byte_o),
    .byte_index_o   (byte_index_o),
    .frame_length_o (frame_length_o),
    .has_data_o     (has_data_o),
    .last_o         (last_o)
  );

  always #1 clk_i = ~clk_i;

  task automatic reload_idle();
    idle_count = (timeout_setting == '0) ? LEN_W'(1) : timeout_setting;
  endtask

  task automatic close_frame();
    rx_phase   = PH_HUNT;
    bytes_seen = '0;
    body_sum   = '0;
    idle_count = '0;
  endtask

  // updates the receiver state for one accepted transaction and queues its results
  task automatic predict_item(input logic cmd, input logic [BYTE_W-1:0] b);
    if (cmd == CMD_TICK) begin
      if (rx_phase != PH_HUNT && idle_count != '0) begin
        live_items++;
        idle_count--;
        if (idle_count == '0) begin
          close_frame();
          expected_results.push_back('{ST_TIMEOUT, '0, '0, '0, 1'b0, 1'b1});
        end
      end
    end else begin
      if (rx_phase != PH_HUNT || b == START_MARK) live_items++;
      case (rx_phase)
        PH_HUNT: begin
          if (b == START_MARK) begin
            rx_phase   = PH_LEN_HI;
            bytes_seen = '0;
            body_sum   = '0;
            reload_idle();
          end
        end
        PH_LEN_HI: begin
          declared_len = {b, 8'h00};
          rx_phase     = PH_LEN_LO;
          reload_idle();
        end
        PH_LEN_LO: begin
          declared_len[7:0] = b;
          rx_phase          = PH_BODY;
          reload_idle();
        end
        default: begin
          if (bytes_seen < declared_len) begin
            // bytes past the store are counted and summed but not kept
            if (bytes_seen < DEPTH) body_store[bytes_seen] = b;
            bytes_seen++;
            body_sum += b;
            reload_idle();
          end else begin
            if (declared_len > DEPTH) begin
              expected_results.push_back('{ST_OVER, '0, '0, declared_len, 1'b0, 1'b1});
            end else if (b != CSUM_BASE - body_sum) begin
              expected_results.push_back('{ST_CSUM, '0, '0, declared_len, 1'b0, 1'b1});
            end else if (declared_len == '0) begin
              expected_results.push_back('{ST_GOOD, '0, '0, '0, 1'b0, 1'b1});
            end else begin
              for (int i = 0; i < declared_len; i++) begin
                expected_results.push_back('{ST_GOOD, body_store[i], BYTE_IDX_W'(i),
                                             declared_len, 1'b1, (i == declared_len - 1)});
              end
            end
            close_frame();
          end
        end
      endcase
    end
  endtask

  task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    command_i <= cmd;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full);
    predict_item(cmd, b);
  endtask

  task automatic send_tick();
    send_item(CMD_TICK, 8'($urandom));
  endtask

  function automatic byte_q_t random_body(input int unsigned n);
    byte_q_t body;
    repeat (n) body.push_back(8'($urandom));
    return body;
  endfunction

  function automatic logic [BYTE_W-1:0] good_csum(input byte_q_t body);
    logic [BYTE_W-1:0] sum;
    sum = '0;
    foreach (body[i]) sum += body[i];
    return CSUM_BASE - sum;
  endfunction

  task automatic send_frame(input logic [LEN_W-1:0] len, input byte_q_t body,
                            input bit csum_ok);
    send_item(CMD_BYTE, START_MARK);
    send_item(CMD_BYTE, len[15:8]);
    send_item(CMD_BYTE, len[7:0]);
    foreach (body[i]) send_item(CMD_BYTE, body[i]);
    send_item(CMD_BYTE, csum_ok ? good_csum(body) : good_csum(body) ^ 8'($urandom_range(1, 255)));
  endtask

  // closes any partial frame by the shorter way, then drains the result side
  task automatic settle();
    while (rx_phase != PH_HUNT) begin
      if (rx_phase != PH_BODY || declared_len - bytes_seen < idle_count) begin
        send_item(CMD_BYTE, 8'h00);
      end else begin
        send_tick();
      end
    end
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [LEN_W-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    timeout_setting = value;
  endtask

  // mostly well-formed frames; with a short timer also cut frames, stray ticks and noise
  task automatic random_frame();
    byte_q_t           seq;
    logic [LEN_W-1:0]  len;
    int unsigned       pick;
    int unsigned       cut;
    bit                lively;
    lively = (timeout_setting <= 64);
    pick   = $urandom_range(99);
    if (pick < 60) len = LEN_W'($urandom_range(0, DEPTH));
    else if (pick < 85) len = LEN_W'($urandom_range(DEPTH + 1, DEPTH + 8));
    else if (pick < 92 && lively) len = LEN_W'($urandom);
    else len = LEN_W'($urandom_range(0, 4));
    seq = random_body((len > 40) ? 6 : len);
    if (len <= 40) begin
      seq.push_back(($urandom_range(99) < 80) ? good_csum(seq)
                                              : good_csum(seq) ^ 8'($urandom_range(1, 255)));
    end
    seq.push_front(len[7:0]);
    seq.push_front(len[15:8]);
    seq.push_front(START_MARK);
    cut = seq.size();
    if (lively && $urandom_range(99) < 10) cut = $urandom_range(1, seq.size() - 1);
    for (int i = 0; i < cut; i++) begin
      if (lively && $urandom_range(99) < 8) repeat ($urandom_range(1, 3)) send_tick();
      send_item(CMD_BYTE, seq[i]);
    end
    // a quiet line lets the timer bring the parser back to hunting
    if (lively && (cut < seq.size() || len > 40 || $urandom_range(99) < 10)) begin
      repeat (timeout_setting + 1) send_tick();
    end
    if (lively && $urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 3)) send_item(CMD_BYTE, 8'($urandom));
    end
  endtask

  task automatic test_default_timeout();
    // timer left at its reset value
    send_item(CMD_BYTE, START_MARK);
    repeat (200) send_tick();
    send_frame(16'd2, random_body(2), 1'b1);
  endtask

  task automatic test_directed_frames();
    byte_q_t body;
    write_timeout(16'hFFFF);
    // noise and ticks while hunting are dropped
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'hFF);
    send_tick();
    send_frame(16'd0, body, 1'b1);
    send_frame(16'd0, body, 1'b0);
    body = {8'hFF};
    send_frame(16'd1, body, 1'b1);
    body = random_body(DEPTH - 3);
    body.push_front(START_MARK);
    body.push_front(8'hFF);
    body.push_front(8'h00);
    send_frame(LEN_W'(DEPTH), body, 1'b1);
    send_frame(16'd3, random_body(3), 1'b0);
    send_frame(LEN_W'(DEPTH + 1), random_body(DEPTH + 1), 1'b1);
    send_frame(LEN_W'(DEPTH + 4), random_body(DEPTH + 4), 1'b0);
  endtask

  task automatic test_timeout_extremes();
    write_timeout(16'd0);
    send_item(CMD_BYTE, START_MARK);
    send_tick();
    send_item(CMD_BYTE, START_MARK);
    send_item(CMD_BYTE, 8'h00);
    send_tick();
    write_timeout(16'd1);
    send_item(CMD_BYTE, START_MARK);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'hFF);
    send_item(CMD_BYTE, 8'h5A);
    send_tick();
    // each byte reloads the timer, so two ticks between bytes never expire
    write_timeout(16'd3);
    send_item(CMD_BYTE, START_MARK);
    send_item(CMD_BYTE, 8'h00);
    send_item(CMD_BYTE, 8'h02);
    repeat (2) send_tick();
    send_item(CMD_BYTE, 8'h11);
    repeat (2) send_tick();
    send_item(CMD_BYTE, 8'h22);
    repeat (2) send_tick();
    send_item(CMD_BYTE, CSUM_BASE - 8'h33);
  endtask

  task automatic test_backpressure();
    write_timeout(TIMEOUT_RESET);
    -> hold_go;
    repeat (4) send_frame(LEN_W'(DEPTH), random_body(DEPTH), 1'b1);
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          pop_stall_pct = 0;
          write_timeout(16'd1);
        end
        1: begin
          send_idle_pct = 48;
          pop_stall_pct = 0;
          write_timeout(LEN_W'($urandom_range(2, 12)));
        end
        2: begin
          send_idle_pct = 0;
          pop_stall_pct = 48;
          write_timeout(LEN_W'($urandom_range(13, 64)));
        end
        default: begin
          send_idle_pct = 7;
          pop_stall_pct = 7;
          write_timeout(16'hFFFF);
        end
      endcase
      goal = live_items + RANDOM_ITEMS / 4;
      while (live_items < goal) random_frame();
    end
  endtask

  function automatic void check_field(input string name, input logic [LEN_W-1:0] want,
                                      input logic [LEN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected, status %0d", status_o);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, status_o);
        check_field("data_byte", want.data, data_byte_o);
        check_field("byte_index", want.idx, byte_index_o);
        check_field("frame_length", want.len, frame_length_o);
        check_field("has_data", want.has_data, has_data_o);
        check_field("last", want.last, last_o);
      end
    end
    pop <= !holding && ($urandom_range(99) >= pop_stall_pct);
  end

  // long hold-off of the result side so the block backs up into its input
  initial begin
    forever begin
      @(hold_go);
      @(posedge clk_i);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      holding <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_timeout();
    test_directed_frames();
    test_timeout_extremes();
    test_backpressure();
    test_random_traffic();
    settle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
